>>> rtl/tlvav_pkg.sv
package tlvav_pkg;

   // Dictionary layout constants.
   localparam logic [2:0] HDR_LAST_IDX = 3'd6;   // seven header bytes, indices 0 to 6
   localparam logic [7:0] UINT_TYPE    = 8'd2;
   localparam logic [7:0] HOURS_MAX    = 8'd255;
   localparam logic [2:0] VALUE_KEEP   = 3'd4;   // value bytes kept in the accumulator

   // Queue geometry shared by the request and result queues.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_VERSION_KEY    = 3'd0,
      REG_CAPABILITY_KEY = 3'd1,
      REG_HOURS_KEY      = 3'd2,
      REG_EXPECTED_VER   = 3'd3,
      REG_ALLOWED_CAPS   = 3'd4
   } csr_reg_type;

   // Classified request as it travels from the front to the parser.
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_END  = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

   // One result of the identification check.
   typedef struct packed {
      logic        accepted;
      logic [7:0]  version_out;
      logic [31:0] capabilities_out;
      logic [7:0]  hours_out;
   } result_type;

endpackage

>>> rtl/tlvav_front.sv
module tlvav_front
   import tlvav_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_i,
   input  logic       kind_i,
   input  logic [7:0] data_byte_i,
   output logic       full_o,
   output logic       item_valid_o,
   output item_type   item_o,
   input  logic       item_pop_i
);

   item_type               entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;
   item_type               item_in;
   logic                   do_push;
   logic                   do_pop;

   // Classify the incoming request: a data byte or the end of a dictionary.
   always_comb begin
      item_in.op   = kind_i ? OP_END : OP_BYTE;
      item_in.data = data_byte_i;
   end

   assign full_o       = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign item_valid_o = (count_ff != '0);
   assign item_o       = entry_ff[rd_ptr_ff];
   assign do_push      = push_i && !full_o;
   assign do_pop       = item_pop_i && item_valid_o;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

>>> rtl/tlvav_rsp_fifo.sv
module tlvav_rsp_fifo
   import tlvav_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_i,
   input  result_type result_i,
   output logic       full_o,
   output logic       empty_o,
   output result_type result_o,
   input  logic       pop_i
);

   result_type             entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full_o   = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty_o  = (count_ff == '0);
   assign result_o = entry_ff[rd_ptr_ff];
   assign do_push  = push_i && !full_o;
   assign do_pop   = pop_i && !empty_o;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= result_i;
      end
   end

`ifndef ASSERT_OFF
   // The parser must hold back an end request while the result queue is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !full_o)
      else $error("Result pushed into a full queue.");

   // A result that is popped leaves the queue one entry emptier unless one arrives.
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("Result queue count did not drop after a pop.");
`endif

endmodule

>>> rtl/tlvav_parser.sv
module tlvav_parser
   import tlvav_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_i,
   input  logic [CSR_INDEX_W-1:0] csr_index_i,
   input  logic [31:0]            csr_data_i,
   input  logic                   item_valid_i,
   input  item_type               item_i,
   output logic                   item_pop_o,
   input  logic                   rsp_full_i,
   output logic                   rsp_push_o,
   output result_type             result_o
);

   typedef enum logic [3:0] {
      PH_COUNT  = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_VALUE  = 4'b0100,
      PH_TAIL   = 4'b1000
   } phase_type;

   // Configuration registers.
   logic [31:0] version_key_ff, capability_key_ff, hours_key_ff;
   logic [31:0] expected_version_ff, allowed_caps_ff;

   // Parse state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  tuples_left_ff, tuples_left_in;
   logic [2:0]  header_index_ff, header_index_in;
   logic [31:0] key_accum_ff, key_accum_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] value_length_ff, value_length_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  value_pos_ff, value_pos_in;
   logic [31:0] value_accum_ff, value_accum_in;
   logic        seen_version_ff, seen_version_in;
   logic        seen_caps_ff, seen_caps_in;
   logic [31:0] version_ff, version_in;
   logic [31:0] caps_ff, caps_in;
   logic [31:0] hours_ff, hours_in;
   logic        failed_ff, failed_in;

   logic        take;
   logic        is_end;
   logic [7:0]  b;
   logic        fin;
   logic [15:0] fin_len;
   logic        value_ok;
   logic        check_ok;

   assign is_end     = (item_i.op == OP_END);
   assign b          = item_i.data;
   assign take       = item_valid_i && (!is_end || !rsp_full_i);
   assign item_pop_o = take;
   assign rsp_push_o = take && is_end;

   // Identification checks on the collected values, used at the end request.
   always_comb begin
      check_ok = !failed_ff && (phase_ff == PH_TAIL) &&
                 seen_version_ff && (version_ff == expected_version_ff) &&
                 seen_caps_ff && (caps_ff != '0) &&
                 ((caps_ff & ~allowed_caps_ff) == '0);
      result_o = '0;
      if (check_ok) begin
         result_o.accepted         = 1'b1;
         result_o.version_out      = version_ff[7:0];
         result_o.capabilities_out = caps_ff;
         result_o.hours_out        = (hours_ff[31:8] != '0) ? HOURS_MAX : hours_ff[7:0];
      end
   end

   // Byte parser: header assembly, value collection and tuple completion.
   always_comb begin
      phase_in        = phase_ff;
      tuples_left_in  = tuples_left_ff;
      header_index_in = header_index_ff;
      key_accum_in    = key_accum_ff;
      type_in         = type_ff;
      value_length_in = value_length_ff;
      bytes_left_in   = bytes_left_ff;
      value_pos_in    = value_pos_ff;
      value_accum_in  = value_accum_ff;
      seen_version_in = seen_version_ff;
      seen_caps_in    = seen_caps_ff;
      version_in      = version_ff;
      caps_in         = caps_ff;
      hours_in        = hours_ff;
      failed_in       = failed_ff;
      fin             = 1'b0;
      fin_len         = value_length_ff;
      value_ok        = 1'b0;

      if (take && is_end) begin
         // The end request closes the dictionary and clears all parse state.
         phase_in        = PH_COUNT;
         tuples_left_in  = '0;
         header_index_in = '0;
         key_accum_in    = '0;
         type_in         = '0;
         value_length_in = '0;
         bytes_left_in   = '0;
         value_pos_in    = '0;
         value_accum_in  = '0;
         seen_version_in = 1'b0;
         seen_caps_in    = 1'b0;
         version_in      = '0;
         caps_in         = '0;
         hours_in        = '0;
         failed_in       = 1'b0;
      end else if (take && !failed_ff) begin
         unique case (phase_ff)
            PH_COUNT: begin
               tuples_left_in  = b;
               header_index_in = '0;
               key_accum_in    = '0;
               phase_in        = (b == '0) ? PH_TAIL : PH_HEADER;
            end
            PH_HEADER: begin
               if (header_index_ff[2] == 1'b0) begin
                  key_accum_in = key_accum_ff |
                                 ({24'h0, b} << {header_index_ff[1:0], 3'b000});
               end else if (header_index_ff == 3'd4) begin
                  type_in = b;
               end else if (header_index_ff == 3'd5) begin
                  value_length_in = {8'h00, b};
               end else begin
                  value_length_in = value_length_ff | {b, 8'h00};
               end
               if (header_index_ff != HDR_LAST_IDX) begin
                  header_index_in = header_index_ff + 1'b1;
               end else begin
                  bytes_left_in  = value_length_in;
                  value_accum_in = '0;
                  value_pos_in   = '0;
                  fin_len        = value_length_in;
                  if (value_length_in == '0) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = PH_VALUE;
                  end
               end
            end
            PH_VALUE: begin
               if (value_pos_ff != VALUE_KEEP) begin
                  value_accum_in = value_accum_ff |
                                   ({24'h0, b} << {value_pos_ff[1:0], 3'b000});
                  value_pos_in   = value_pos_ff + 1'b1;
               end
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == 16'd1) begin
                  fin = 1'b1;
               end
            end
            PH_TAIL: begin
            end
            default: begin
            end
         endcase

         // Tuple completion: store a well-formed value under a configured key, or flag a malformed one.
         if (fin) begin
            value_ok = (type_ff == UINT_TYPE) &&
                       (fin_len == 16'd1 || fin_len == 16'd2 || fin_len == 16'd4);
            if (key_accum_ff == version_key_ff) begin
               if (value_ok) begin
                  version_in      = value_accum_in;
                  seen_version_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end else if (key_accum_ff == capability_key_ff) begin
               if (value_ok) begin
                  caps_in      = value_accum_in;
                  seen_caps_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end else if (key_accum_ff == hours_key_ff) begin
               if (value_ok) begin
                  hours_in = value_accum_in;
               end else begin
                  failed_in = 1'b1;
               end
            end
            tuples_left_in  = tuples_left_ff - 1'b1;
            header_index_in = '0;
            key_accum_in    = '0;
            value_accum_in  = '0;
            phase_in        = (tuples_left_ff == 8'd1) ? PH_TAIL : PH_HEADER;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         version_key_ff      <= 32'd0;
         capability_key_ff   <= 32'd1;
         hours_key_ff        <= 32'd2;
         expected_version_ff <= 32'd1;
         allowed_caps_ff     <= 32'd63;
      end else if (csr_write_i) begin
         unique case (csr_index_i)
            REG_VERSION_KEY:    version_key_ff      <= csr_data_i;
            REG_CAPABILITY_KEY: capability_key_ff   <= csr_data_i;
            REG_HOURS_KEY:      hours_key_ff        <= csr_data_i;
            REG_EXPECTED_VER:   expected_version_ff <= csr_data_i;
            REG_ALLOWED_CAPS:   allowed_caps_ff     <= csr_data_i;
            default: begin
            end
         endcase
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_COUNT;
         tuples_left_ff  <= '0;
         header_index_ff <= '0;
         key_accum_ff    <= '0;
         type_ff         <= '0;
         value_length_ff <= '0;
         bytes_left_ff   <= '0;
         value_pos_ff    <= '0;
         value_accum_ff  <= '0;
         seen_version_ff <= 1'b0;
         seen_caps_ff    <= 1'b0;
         version_ff      <= '0;
         caps_ff         <= '0;
         hours_ff        <= '0;
         failed_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         tuples_left_ff  <= tuples_left_in;
         header_index_ff <= header_index_in;
         key_accum_ff    <= key_accum_in;
         type_ff         <= type_in;
         value_length_ff <= value_length_in;
         bytes_left_ff   <= bytes_left_in;
         value_pos_ff    <= value_pos_in;
         value_accum_ff  <= value_accum_in;
         seen_version_ff <= seen_version_in;
         seen_caps_ff    <= seen_caps_in;
         version_ff      <= version_in;
         caps_ff         <= caps_in;
         hours_ff        <= hours_in;
         failed_ff       <= failed_in;
      end
   end

`ifndef ASSERT_OFF
   // Once a malformed value is seen, data bytes no longer move the parser.
   a_failed_holds: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && take && !is_end) |=> ($stable(phase_ff) && failed_ff))
      else $error("Parser advanced after a sticky failure.");

   // While collecting a value there is always at least one byte outstanding.
   a_value_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> (bytes_left_ff != '0))
      else $error("Value phase with no bytes left.");

   // An end request leaves the parser waiting for a fresh count byte.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (take && is_end) |=> (phase_ff == PH_COUNT && !failed_ff && !seen_version_ff))
      else $error("Parse state not cleared after an end request.");
`endif

endmodule

>>> rtl/tlv_announce_validator_top.sv
// Identification checker for a serialised tuple dictionary fed one byte per request
// (req_kind low) and closed by an end request (req_kind high), which yields exactly
// one result; data bytes yield none. Both sides behave as queues: a request is
// taken when push is high and full is low, and a result is taken when pop is high
// and empty is low. The block sustains one request per clock cycle: a two-entry
// request queue feeds a parser that consumes one byte each cycle, and when the parser
// takes an end request it writes the result into the result queue, whose head drives
// the result ports. Only an end request can stall the parser, and only while the
// two-entry result queue is full. The configuration registers are always ready and
// should be written while no dictionary is in flight.
module tlv_announce_validator_top
   import tlvav_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_kind,
   input  logic [7:0]             req_data_byte,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_accepted,
   output logic [7:0]             rsp_version_out,
   output logic [31:0]            rsp_capabilities_out,
   output logic [7:0]             rsp_hours_out,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic       item_valid;
   item_type   item;
   logic       item_pop;
   logic       rsp_full;
   logic       rsp_push;
   result_type result_new;
   result_type result_head;

   assign csr_ready = 1'b1;

   // Front: takes and classifies requests.
   tlvav_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push_i       (push),
      .kind_i       (req_kind),
      .data_byte_i  (req_data_byte),
      .full_o       (full),
      .item_valid_o (item_valid),
      .item_o       (item),
      .item_pop_i   (item_pop)
   );

   // Back: parses the dictionary and runs the checks.
   tlvav_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .csr_write_i  (csr_valid && csr_ready),
      .csr_index_i  (csr_index),
      .csr_data_i   (csr_data),
      .item_valid_i (item_valid),
      .item_i       (item),
      .item_pop_o   (item_pop),
      .rsp_full_i   (rsp_full),
      .rsp_push_o   (rsp_push),
      .result_o     (result_new)
   );

   // Results wait here until they are popped.
   tlvav_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_i   (rsp_push),
      .result_i (result_new),
      .full_o   (rsp_full),
      .empty_o  (empty),
      .result_o (result_head),
      .pop_i    (pop)
   );

   assign rsp_accepted         = result_head.accepted;
   assign rsp_version_out      = result_head.version_out;
   assign rsp_capabilities_out = result_head.capabilities_out;
   assign rsp_hours_out        = result_head.hours_out;

endmodule

>>> tb/tb_tlv_announce_validator_top.sv
`timescale 1ns / 100ps

module tb_tlv_announce_validator_top;
   import tlvav_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // Parse phases of the predictor.
   typedef enum logic [1:0] {
      PS_COUNT,
      PS_HEADER,
      PS_VALUE,
      PS_TAIL
   } parse_phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic                   req_kind = OP_BYTE;
   logic [7:0]             req_data_byte = 8'd0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic                   rsp_accepted;
   logic [7:0]             rsp_version_out;
   logic [31:0]            rsp_capabilities_out;
   logic [7:0]             rsp_hours_out;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_VERSION_KEY;
   logic [31:0]            csr_data = 32'd0;

   tlv_announce_validator_top u_top (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_kind             (req_kind),
      .req_data_byte        (req_data_byte),
      .empty                (empty),
      .pop                  (pop),
      .rsp_accepted         (rsp_accepted),
      .rsp_version_out      (rsp_version_out),
      .rsp_capabilities_out (rsp_capabilities_out),
      .rsp_hours_out        (rsp_hours_out),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   // Register copies held by the predictor.
   logic [31:0] cfg_version_key   = 32'd0;
   logic [31:0] cfg_caps_key      = 32'd1;
   logic [31:0] cfg_hours_key     = 32'd2;
   logic [31:0] cfg_expected_ver  = 32'd1;
   logic [31:0] cfg_allowed_caps  = 32'd63;

   // Parser state of the predictor.
   parse_phase_type pr_phase   = PS_COUNT;
   logic [7:0]   pr_tuples     = 8'd0;
   logic [2:0]   pr_hdr_idx    = 3'd0;
   logic [31:0]  pr_key        = 32'd0;
   logic [7:0]   pr_type       = 8'd0;
   logic [15:0]  pr_len        = 16'd0;
   logic [15:0]  pr_left       = 16'd0;
   logic [31:0]  pr_value      = 32'd0;
   logic         pr_seen_ver   = 1'b0;
   logic         pr_seen_caps  = 1'b0;
   logic [31:0]  pr_version    = 32'd0;
   logic [31:0]  pr_caps       = 32'd0;
   logic [31:0]  pr_hours      = 32'd0;
   logic         pr_failed     = 1'b0;

   result_type   expected_results[$];
   logic [7:0]   dict_bytes[$];

   int unsigned  cycle_count = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  requests_sent = 0;
   int unsigned  dict_count = 0;
   int unsigned  accepted_count = 0;
   int unsigned  pop_idle_left = 0;
   logic         quiet = 1'b0;

   // Clears all parse state after an end request; registers are untouched.
   task automatic clear_parser();
      pr_phase     = PS_COUNT;
      pr_tuples    = 8'd0;
      pr_hdr_idx   = 3'd0;
      pr_key       = 32'd0;
      pr_type      = 8'd0;
      pr_len       = 16'd0;
      pr_left      = 16'd0;
      pr_value     = 32'd0;
      pr_seen_ver  = 1'b0;
      pr_seen_caps = 1'b0;
      pr_version   = 32'd0;
      pr_caps      = 32'd0;
      pr_hours     = 32'd0;
      pr_failed    = 1'b0;
   endtask

   function automatic logic value_is_uint();
      return pr_type == UINT_TYPE && (pr_len == 16'd1 || pr_len == 16'd2 || pr_len == 16'd4);
   endfunction

   // Stores a finished tuple under its key; the version key takes priority over the
   // capability key, which takes priority over the hours key.
   task automatic complete_tuple();
      if (pr_key == cfg_version_key) begin
         if (value_is_uint()) begin
            pr_version  = pr_value;
            pr_seen_ver = 1'b1;
         end else begin
            pr_failed = 1'b1;
         end
      end else if (pr_key == cfg_caps_key) begin
         if (value_is_uint()) begin
            pr_caps      = pr_value;
            pr_seen_caps = 1'b1;
         end else begin
            pr_failed = 1'b1;
         end
      end else if (pr_key == cfg_hours_key) begin
         if (value_is_uint()) pr_hours = pr_value;
         else pr_failed = 1'b1;
      end
      pr_tuples  = pr_tuples - 8'd1;
      pr_hdr_idx = 3'd0;
      pr_key     = 32'd0;
      pr_value   = 32'd0;
      pr_phase   = (pr_tuples == 8'd0) ? PS_TAIL : PS_HEADER;
   endtask

   // Advances the predicted parser by one data byte.
   task automatic parse_byte(input logic [7:0] b);
      logic [15:0] pos;
      if (pr_failed) return;
      unique case (pr_phase)
         PS_COUNT: begin
            pr_tuples  = b;
            pr_hdr_idx = 3'd0;
            pr_key     = 32'd0;
            pr_phase   = (b == 8'd0) ? PS_TAIL : PS_HEADER;
         end
         PS_HEADER: begin
            if (pr_hdr_idx < 3'd4) pr_key = pr_key | ({24'd0, b} << (8 * pr_hdr_idx));
            else if (pr_hdr_idx == 3'd4) pr_type = b;
            else if (pr_hdr_idx == 3'd5) pr_len = {8'd0, b};
            else pr_len = {b, pr_len[7:0]};
            if (pr_hdr_idx != HDR_LAST_IDX) begin
               pr_hdr_idx = pr_hdr_idx + 3'd1;
            end else begin
               pr_left  = pr_len;
               pr_value = 32'd0;
               if (pr_len == 16'd0) complete_tuple();
               else pr_phase = PS_VALUE;
            end
         end
         PS_VALUE: begin
            pos = pr_len - pr_left;
            if (pos < 16'(VALUE_KEEP)) pr_value = pr_value | ({24'd0, b} << (8 * pos[1:0]));
            pr_left = pr_left - 16'd1;
            if (pr_left == 16'd0) complete_tuple();
         end
         default: ;
      endcase
   endtask

   // Works out the result of an end request and resets the parser.
   task automatic close_dictionary(output result_type r);
      logic ok;
      ok = !pr_failed && pr_phase == PS_TAIL && pr_seen_ver &&
           pr_version == cfg_expected_ver && pr_seen_caps && pr_caps != 32'd0 &&
           (pr_caps & ~cfg_allowed_caps) == 32'd0;
      r = '0;
      if (ok) begin
         r.accepted         = 1'b1;
         r.version_out      = pr_version[7:0];
         r.capabilities_out = pr_caps;
         r.hours_out        = (pr_hours > 32'(HOURS_MAX)) ? HOURS_MAX : pr_hours[7:0];
      end
      clear_parser();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at cycle %0d: %s got 0x%0h, expected 0x%0h",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Sends one request, sometimes after an idle burst, and predicts its effect once taken.
   task automatic send_request(input op_type op, input logic [7:0] b);
      result_type r;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      push          <= 1'b1;
      req_kind      <= op;
      req_data_byte <= b;
      do @(posedge clock); while (full);
      requests_sent++;
      if (op == OP_BYTE) begin
         parse_byte(b);
      end else begin
         close_dictionary(r);
         expected_results.push_back(r);
         dict_count++;
         if (r.accepted) accepted_count++;
      end
   endtask

   // Sends the bytes gathered in dict_bytes, then the closing end request.
   task automatic send_dictionary();
      foreach (dict_bytes[i]) send_request(OP_BYTE, dict_bytes[i]);
      send_request(OP_END, 8'($urandom));
      dict_bytes.delete();
   endtask

   task automatic append_tuple(input logic [31:0] key, input logic [7:0] typ,
                               input logic [15:0] len, input logic [31:0] value);
      for (int i = 0; i < 4; i++) dict_bytes.push_back(key[8*i +: 8]);
      dict_bytes.push_back(typ);
      dict_bytes.push_back(len[7:0]);
      dict_bytes.push_back(len[15:8]);
      for (int i = 0; i < int'(len); i++) begin
         if (i < 4) dict_bytes.push_back(value[8*i +: 8]);
         else dict_bytes.push_back(8'($urandom));
      end
   endtask

   // Stops new requests and waits until every result has come out and the block is quiet.
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         REG_VERSION_KEY:    cfg_version_key  = val;
         REG_CAPABILITY_KEY: cfg_caps_key     = val;
         REG_HOURS_KEY:      cfg_hours_key    = val;
         REG_EXPECTED_VER:   cfg_expected_ver = val;
         REG_ALLOWED_CAPS:   cfg_allowed_caps = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_registers(input logic [31:0] vkey, input logic [31:0] ckey,
                                    input logic [31:0] hkey, input logic [31:0] ever,
                                    input logic [31:0] caps);
      wait_idle();
      write_register(REG_VERSION_KEY, vkey);
      write_register(REG_CAPABILITY_KEY, ckey);
      write_register(REG_HOURS_KEY, hkey);
      write_register(REG_EXPECTED_VER, ever);
      write_register(REG_ALLOWED_CAPS, caps);
   endtask

   // Builds one dictionary: mostly well formed with random content, some with trailing
   // bytes, some cut short, and a few of pure noise.
   task automatic send_random_dictionary();
      int unsigned style;
      int unsigned n;
      int unsigned pick;
      int unsigned r;
      logic [31:0] key;
      logic [31:0] value;
      logic [7:0]  typ;
      logic [15:0] len;
      style = $urandom_range(0, 19);
      if (style == 0) begin
         n = $urandom_range(0, 20);
         repeat (n) dict_bytes.push_back(8'($urandom));
      end else begin
         n = (style < 4) ? $urandom_range(0, 6) : $urandom_range(2, 4);
         dict_bytes.push_back(n[7:0]);
         for (int k = 0; k < int'(n); k++) begin
            pick = $urandom_range(0, 9);
            typ  = ($urandom_range(0, 15) == 0) ? 8'($urandom) : UINT_TYPE;
            r    = $urandom_range(0, 15);
            if (r < 10) len = 16'd4;
            else if (r < 12) len = 16'd1;
            else if (r == 12) len = 16'd2;
            else if (r == 13) len = 16'd0;
            else if (r == 14) len = 16'($urandom_range(3, 9));
            else if ($urandom_range(0, 7) == 0) len = 16'h0100 + 16'($urandom_range(0, 40));
            else len = 16'($urandom_range(5, 40));
            value = $urandom;
            if (pick < 3) begin
               key = cfg_version_key;
               if ($urandom_range(0, 4) != 0) value = cfg_expected_ver;
            end else if (pick < 6) begin
               key = cfg_caps_key;
               if ($urandom_range(0, 4) != 0) value = $urandom & cfg_allowed_caps;
            end else if (pick < 8) begin
               key = cfg_hours_key;
               if ($urandom_range(0, 1) == 0) value = $urandom_range(0, 300);
            end else begin
               key = $urandom;
            end
            append_tuple(key, typ, len, value);
         end
         if (style == 1) repeat ($urandom_range(1, 6)) dict_bytes.push_back(8'($urandom));
         if (style == 2 && dict_bytes.size() > 1)
            dict_bytes = dict_bytes[0:$urandom_range(0, dict_bytes.size() - 2)];
      end
      send_dictionary();
   endtask

   task automatic run_random_dictionaries(input int unsigned quota);
      int unsigned start;
      start = requests_sent;
      while (requests_sent - start < quota) send_random_dictionary();
   endtask

   // An end request with nothing before it, and one cut off inside a header.
   task automatic test_empty_and_truncated();
      send_request(OP_END, 8'hFF);
      dict_bytes = '{8'd1, 8'd0, 8'd0};
      send_dictionary();
   endtask

   // A complete announcement under the reset keys, with hours above the saturation point.
   task automatic test_valid_announce();
      dict_bytes.push_back(8'd3);
      append_tuple(32'd0, UINT_TYPE, 16'd1, 32'd1);
      append_tuple(32'd1, UINT_TYPE, 16'd4, 32'h0000_003F);
      append_tuple(32'd2, UINT_TYPE, 16'd2, 32'h0000_12FF);
      send_dictionary();
   endtask

   // A zero count goes straight to the tail, so the version is missing.
   task automatic test_zero_count();
      dict_bytes.push_back(8'd0);
      send_dictionary();
   endtask

   task automatic test_random_defaults();
      run_random_dictionaries(250);
   endtask

   task automatic test_extreme_registers();
      program_registers(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF);
      run_random_dictionaries(250);
   endtask

   // Equal keys: all three, then only the capability and hours keys.
   task automatic test_coinciding_keys();
      logic [31:0] k;
      k = $urandom;
      program_registers(k, k, k, $urandom_range(0, 3), $urandom);
      run_random_dictionaries(120);
      k = $urandom;
      program_registers(~k, k, k, $urandom, $urandom);
      run_random_dictionaries(120);
   endtask

   // No capability bit allowed, so every dictionary closes with a rejection.
   task automatic test_closed_mask();
      program_registers($urandom, $urandom, $urandom, 32'd0, 32'd0);
      run_random_dictionaries(150);
   endtask

   task automatic test_random_registers();
      repeat (3) begin
         program_registers($urandom, $urandom, $urandom, $urandom, $urandom);
         run_random_dictionaries(100);
      end
   endtask

   // Final stretch with neither side idling.
   task automatic test_back_to_back();
      program_registers($urandom_range(0, 7), $urandom_range(8, 15), $urandom_range(16, 31),
                        $urandom_range(0, 255), 32'h0000_FFFF);
      quiet = 1'b1;
      run_random_dictionaries(150);
   endtask

   // Result checking against the oldest expectation, and random stalls on the pop side.
   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, accepted", 32'(rsp_accepted), 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_accepted !== want.accepted)
               report_mismatch("accepted", 32'(rsp_accepted), 32'(want.accepted));
            if (rsp_version_out !== want.version_out)
               report_mismatch("version_out", 32'(rsp_version_out), 32'(want.version_out));
            if (rsp_capabilities_out !== want.capabilities_out)
               report_mismatch("capabilities_out", rsp_capabilities_out,
                               want.capabilities_out);
            if (rsp_hours_out !== want.hours_out)
               report_mismatch("hours_out", 32'(rsp_hours_out), 32'(want.hours_out));
         end
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (quiet) begin
         pop <= 1'b1;
      end else if (pop_idle_left != 0) begin
         pop_idle_left--;
         pop <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         pop_idle_left = $urandom_range(0, 7);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("tlv_announce_validator_top test failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_truncated();
      test_valid_announce();
      test_zero_count();
      test_random_defaults();
      test_extreme_registers();
      test_coinciding_keys();
      test_closed_mask();
      test_random_registers();
      test_back_to_back();
      wait_idle();
      $display("Sent %0d requests forming %0d dictionaries: %0d accepted, %0d rejected.",
               requests_sent, dict_count, accepted_count, dict_count - accepted_count);
      $display("Register values ranged over reset, extreme, equal-key and random choices.");
      if (mismatch_count == 0) begin
         $display("tlv_announce_validator_top test passed");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("tlv_announce_validator_top test failed");
      end
      $finish;
   end

endmodule
